// ===== src/sdi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdi_pkg
// Types and constants for the SD card native-mode init sequencer.
// ----------------------------------------------------------------------------
package sdi_pkg;

   // sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_GO_IDLE   = 4'd1,
      PH_IF_COND   = 4'd2,
      PH_APP_OP    = 4'd3,
      PH_OP_COND   = 4'd4,
      PH_CID       = 4'd5,
      PH_RCA       = 4'd6,
      PH_SELECT    = 4'd7,
      PH_APP_BUS   = 4'd8,
      PH_BUS_WIDTH = 4'd9,
      PH_BLOCKLEN  = 4'd10,
      PH_DONE      = 4'd11,
      PH_FAILED    = 4'd12
   } phase_type;

   // result actions
   typedef enum logic [2:0] {
      ACT_SEND = 3'd0,
      ACT_WAIT = 3'd1,
      ACT_SLOW = 3'd2,
      ACT_WIDE = 3'd3,
      ACT_FAST = 3'd4,
      ACT_DONE = 3'd5,
      ACT_FAIL = 3'd6
   } action_type;

   // response kinds
   localparam logic [1:0] RK_NONE    = 2'd0;
   localparam logic [1:0] RK_CHECKED = 2'd1;
   localparam logic [1:0] RK_NOCRC   = 2'd2;
   localparam logic [1:0] RK_LONG    = 2'd3;

   // input command codes
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_OUTCOME = 1'b1;

   // outcome codes
   localparam logic [1:0] OUT_OK  = 2'd0;
   localparam logic [1:0] OUT_CRC = 2'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_RESET_ATTEMPTS  = 2'd0;
   localparam logic [1:0] CSR_OP_COND_RETRIES = 2'd1;
   localparam logic [1:0] CSR_VOLTAGE_WINDOW  = 2'd2;
   localparam logic [1:0] CSR_BLOCK_LENGTH    = 2'd3;

   // configuration reset values
   localparam logic [7:0]  RESET_ATTEMPTS_RST  = 8'd74;
   localparam logic [9:0]  OP_COND_RETRIES_RST = 10'd1000;
   localparam logic [8:0]  VOLTAGE_WINDOW_RST  = 9'h1FF;
   localparam logic [11:0] BLOCK_LENGTH_RST    = 12'd512;

   // SD command indexes
   localparam logic [5:0] SD_CMD0   = 6'd0;
   localparam logic [5:0] SD_CMD2   = 6'd2;
   localparam logic [5:0] SD_CMD3   = 6'd3;
   localparam logic [5:0] SD_ACMD6  = 6'd6;
   localparam logic [5:0] SD_CMD7   = 6'd7;
   localparam logic [5:0] SD_CMD8   = 6'd8;
   localparam logic [5:0] SD_CMD16  = 6'd16;
   localparam logic [5:0] SD_ACMD41 = 6'd41;
   localparam logic [5:0] SD_CMD55  = 6'd55;

   // arguments and response bits
   localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
   localparam logic [7:0]  IF_COND_ECHO = 8'hAA;
   localparam logic [31:0] WIDE_BUS_ARG = 32'd2;
   localparam int          HCS_POS      = 30;
   localparam int          OCR_BUSY_POS = 31;
   localparam int          OCR_CCS_POS  = 30;

   // results caused by one item: up to three actions, at most one send
   typedef struct packed {
      logic [1:0]  n;
      action_type  act0;
      action_type  act1;
      action_type  act2;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_arg;
      logic [1:0]  rkind;
      logic        cap;
      logic [15:0] addr;
   } bundle_type;

endpackage

// ===== src/sd_card_init_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// sd_card_init_sequencer_top
// SD card native-mode bring-up sequencer: start or command outcome in, next
// actions (send command, wait, bus width, clock, done, failed) out.
// ----------------------------------------------------------------------------
// An item (start or command outcome) is decided in the cycle it is accepted:
// the phase logic updates the card state and writes all of the item's results
// (one to three) as one entry into a two-entry result queue; an outcome in
// the idle, done or failed phase has no results and writes nothing. The
// first result is presented once the entry is registered and earlier entries
// have left; the rest follow one per cycle while rsp_ready is high. Items overlap
// with the results of earlier items; the output port sets the sustained rate
// (one item per cycle when each has a single result and rsp_ready stays high).
// req_ready drops only when both queue entries hold undelivered results.
module sd_card_init_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [1:0]  req_outcome,
   input  logic [31:0] req_response_word,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [5:0]  rsp_cmd_index,
   output logic [31:0] rsp_cmd_argument,
   output logic [1:0]  rsp_response_kind,
   output logic        rsp_high_capacity,
   output logic [15:0] rsp_card_address,
   output logic        rsp_last
);

   // configuration registers
   logic [7:0]  ra_ff;
   logic [9:0]  ocr_ff;
   logic [8:0]  vw_ff;
   logic [11:0] bl_ff;

   // card state
   sdi_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  attempt_ff, attempt_in;
   logic        v2_ff, v2_in;
   logic        cap_ff, cap_in;
   logic [15:0] rca_ff, rca_in;

   // result queue
   sdi_pkg::bundle_type ent_ff [2];
   sdi_pkg::bundle_type bnd;
   sdi_pkg::bundle_type head;
   logic        wr_ff, rd_ff;
   logic [1:0]  count_ff;
   logic [1:0]  sub_ff;
   logic        accept, push, pop;
   logic        ok, answered;
   sdi_pkg::action_type act;

   always_ff @(posedge clock) begin
      if (reset) begin
         ra_ff  <= sdi_pkg::RESET_ATTEMPTS_RST;
         ocr_ff <= sdi_pkg::OP_COND_RETRIES_RST;
         vw_ff  <= sdi_pkg::VOLTAGE_WINDOW_RST;
         bl_ff  <= sdi_pkg::BLOCK_LENGTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            sdi_pkg::CSR_RESET_ATTEMPTS:  ra_ff  <= csr_wdata[7:0];
            sdi_pkg::CSR_OP_COND_RETRIES: ocr_ff <= csr_wdata[9:0];
            sdi_pkg::CSR_VOLTAGE_WINDOW:  vw_ff  <= csr_wdata[8:0];
            sdi_pkg::CSR_BLOCK_LENGTH:    bl_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign accept   = req_valid && req_ready;
   assign ok       = (req_outcome == sdi_pkg::OUT_OK);
   assign answered = ok || (req_outcome == sdi_pkg::OUT_CRC);

   // phase logic: next card state and the results of this item
   always_comb begin
      phase_in   = phase_ff;
      attempt_in = attempt_ff;
      v2_in      = v2_ff;
      cap_in     = cap_ff;
      rca_in     = rca_ff;
      bnd        = '0;
      if (req_command == sdi_pkg::CMD_START) begin
         attempt_in    = 10'd1;
         v2_in         = 1'b0;
         cap_in        = 1'b0;
         rca_in        = '0;
         bnd.n         = 2'd2;
         bnd.act0      = sdi_pkg::ACT_SLOW;
         bnd.act1      = sdi_pkg::ACT_SEND;
         bnd.cmd_index = sdi_pkg::SD_CMD0;
         bnd.rkind     = sdi_pkg::RK_NONE;
         phase_in      = sdi_pkg::PH_GO_IDLE;
      end else begin
         // default arm of each phase below but IF_COND: fail
         case (phase_ff)
            sdi_pkg::PH_GO_IDLE: begin
               bnd.n = 2'd1;
               if (ok) begin
                  bnd.cmd_index = sdi_pkg::SD_CMD8;
                  bnd.cmd_arg   = sdi_pkg::IF_COND_ARG;
                  bnd.rkind     = sdi_pkg::RK_NOCRC;
                  phase_in      = sdi_pkg::PH_IF_COND;
               end else if (attempt_ff < {2'b00, ra_ff}) begin
                  attempt_in    = attempt_ff + 10'd1;
                  bnd.cmd_index = sdi_pkg::SD_CMD0;
                  bnd.rkind     = sdi_pkg::RK_NONE;
               end else begin
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            sdi_pkg::PH_IF_COND: begin
               v2_in         = answered && (req_response_word[7:0] == sdi_pkg::IF_COND_ECHO);
               attempt_in    = 10'd1;
               bnd.n         = 2'd1;
               bnd.cmd_index = sdi_pkg::SD_CMD55;
               bnd.rkind     = sdi_pkg::RK_CHECKED;
               phase_in      = sdi_pkg::PH_APP_OP;
            end
            sdi_pkg::PH_APP_OP: begin
               bnd.n = 2'd1;
               if (ok) begin
                  bnd.cmd_index                   = sdi_pkg::SD_ACMD41;
                  bnd.cmd_arg[23:15]              = vw_ff;
                  bnd.cmd_arg[sdi_pkg::HCS_POS]   = v2_ff;
                  bnd.rkind                       = sdi_pkg::RK_NOCRC;
                  phase_in                        = sdi_pkg::PH_OP_COND;
               end else begin
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            sdi_pkg::PH_OP_COND: begin
               bnd.n = 2'd1;
               if (answered && req_response_word[sdi_pkg::OCR_BUSY_POS]) begin
                  cap_in        = v2_ff && req_response_word[sdi_pkg::OCR_CCS_POS];
                  bnd.cmd_index = sdi_pkg::SD_CMD2;
                  bnd.rkind     = sdi_pkg::RK_LONG;
                  phase_in      = sdi_pkg::PH_CID;
               end else if (answered && (attempt_ff < ocr_ff)) begin
                  // card still busy: wait, poll again
                  attempt_in    = attempt_ff + 10'd1;
                  bnd.n         = 2'd2;
                  bnd.act0      = sdi_pkg::ACT_WAIT;
                  bnd.act1      = sdi_pkg::ACT_SEND;
                  bnd.cmd_index = sdi_pkg::SD_CMD55;
                  bnd.rkind     = sdi_pkg::RK_CHECKED;
                  phase_in      = sdi_pkg::PH_APP_OP;
               end else begin
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            sdi_pkg::PH_CID: begin
               bnd.n = 2'd1;
               if (answered) begin
                  bnd.cmd_index = sdi_pkg::SD_CMD3;
                  bnd.rkind     = sdi_pkg::RK_CHECKED;
                  phase_in      = sdi_pkg::PH_RCA;
               end else begin
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            sdi_pkg::PH_RCA: begin
               bnd.n = 2'd1;
               if (ok) begin
                  rca_in        = req_response_word[31:16];
                  bnd.cmd_index = sdi_pkg::SD_CMD7;
                  bnd.cmd_arg   = {req_response_word[31:16], 16'h0000};
                  bnd.rkind     = sdi_pkg::RK_CHECKED;
                  phase_in      = sdi_pkg::PH_SELECT;
               end else begin
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            sdi_pkg::PH_SELECT: begin
               bnd.n = 2'd1;
               if (ok) begin
                  bnd.cmd_index = sdi_pkg::SD_CMD55;
                  bnd.cmd_arg   = {rca_ff, 16'h0000};
                  bnd.rkind     = sdi_pkg::RK_CHECKED;
                  phase_in      = sdi_pkg::PH_APP_BUS;
               end else begin
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            sdi_pkg::PH_APP_BUS: begin
               bnd.n = 2'd1;
               if (ok) begin
                  bnd.cmd_index = sdi_pkg::SD_ACMD6;
                  bnd.cmd_arg   = sdi_pkg::WIDE_BUS_ARG;
                  bnd.rkind     = sdi_pkg::RK_CHECKED;
                  phase_in      = sdi_pkg::PH_BUS_WIDTH;
               end else begin
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            sdi_pkg::PH_BUS_WIDTH: begin
               if (!ok) begin
                  bnd.n    = 2'd1;
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end else if (cap_ff) begin
                  // high capacity: no block length command
                  bnd.n    = 2'd3;
                  bnd.act0 = sdi_pkg::ACT_WIDE;
                  bnd.act1 = sdi_pkg::ACT_FAST;
                  bnd.act2 = sdi_pkg::ACT_DONE;
                  phase_in = sdi_pkg::PH_DONE;
               end else begin
                  bnd.n         = 2'd2;
                  bnd.act0      = sdi_pkg::ACT_WIDE;
                  bnd.act1      = sdi_pkg::ACT_SEND;
                  bnd.cmd_index = sdi_pkg::SD_CMD16;
                  bnd.cmd_arg   = {20'h00000, bl_ff};
                  bnd.rkind     = sdi_pkg::RK_CHECKED;
                  phase_in      = sdi_pkg::PH_BLOCKLEN;
               end
            end
            sdi_pkg::PH_BLOCKLEN: begin
               if (ok) begin
                  bnd.n    = 2'd2;
                  bnd.act0 = sdi_pkg::ACT_FAST;
                  bnd.act1 = sdi_pkg::ACT_DONE;
                  phase_in = sdi_pkg::PH_DONE;
               end else begin
                  bnd.n    = 2'd1;
                  bnd.act0 = sdi_pkg::ACT_FAIL;
                  phase_in = sdi_pkg::PH_FAILED;
               end
            end
            default: ; // idle, done, failed: outcome ignored
         endcase
      end
      bnd.cap  = cap_in;
      bnd.addr = rca_in;
   end

   // card state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sdi_pkg::PH_IDLE;
         attempt_ff <= '0;
         v2_ff      <= 1'b0;
         cap_ff     <= 1'b0;
         rca_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         attempt_ff <= attempt_in;
         v2_ff      <= v2_in;
         cap_ff     <= cap_in;
         rca_ff     <= rca_in;
      end
   end

   // result queue control
   assign head      = ent_ff[rd_ff];
   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = accept && (bnd.n != 2'd0);
   assign rsp_last  = (sub_ff == (head.n - 2'd1));
   assign pop       = rsp_valid && rsp_ready && rsp_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
         sub_ff   <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
         if (pop) begin
            sub_ff <= '0;
         end else if (rsp_valid && rsp_ready) begin
            sub_ff <= sub_ff + 2'd1;
         end
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= bnd;
   end

   // pick the current result out of the head entry
   always_comb begin
      case (sub_ff)
         2'd0:    act = head.act0;
         2'd1:    act = head.act1;
         default: act = head.act2;
      endcase
   end

   assign rsp_action        = act;
   assign rsp_cmd_index     = (act == sdi_pkg::ACT_SEND) ? head.cmd_index : '0;
   assign rsp_cmd_argument  = (act == sdi_pkg::ACT_SEND) ? head.cmd_arg : '0;
   assign rsp_response_kind = (act == sdi_pkg::ACT_SEND) ? head.rkind : sdi_pkg::RK_NONE;
   assign rsp_high_capacity = (act == sdi_pkg::ACT_DONE) && head.cap;
   assign rsp_card_address  = head.addr;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_start_results: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == sdi_pkg::CMD_START)) |=> rsp_valid)
      else $error("start item produced no result");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (sub_ff == 2'd0))
      else $error("result index not rewound after last result");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action != sdi_pkg::ACT_SEND)) |->
         ((rsp_cmd_index == 6'd0) && (rsp_cmd_argument == 32'd0)))
      else $error("command fields set on a non-send result");

endmodule
